// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_CANCEL   = 2'd1,
      REQ_TICK     = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_CAN_SCAN,
      ST_TICK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] id;
      logic [15:0] thread;
      logic [15:0] rpc;
   } entry_type;

   typedef struct packed {
      logic        status;
      logic [31:0] new_id;
      logic        expired;
      logic [31:0] expired_id;
      logic [15:0] expired_thread;
      logic [15:0] expired_rpc;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_next;
      logic emit_full;
      logic emit_plain;
      logic insert;
      logic remove;
      logic tick;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic scan_end;
      logic ins_stop;
      logic id_hit;
      logic out_taken;
      logic out_last;
   } stat_type;

endpackage

// ===== hw/rtl/stq_ctrl.sv =====
module stq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_kind,
   output logic               req_tready,
   input  stq_pkg::stat_type  stat,
   output stq_pkg::cmd_type   cmd
);
   import stq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (req_kind)
                  REQ_REGISTER: begin
                     if (stat.full) begin
                        cmd.emit_full = 1'b1;
                        state_in      = ST_OUT;
                     end else begin
                        state_in = ST_INS_SCAN;
                     end
                  end
                  REQ_CANCEL: state_in = ST_CAN_SCAN;
                  REQ_TICK:   state_in = ST_TICK;
                  default: begin
                     cmd.emit_plain = 1'b1;
                     state_in       = ST_OUT;
                  end
               endcase
            end
         end
         ST_INS_SCAN: begin
            if (stat.ins_stop) begin
               cmd.insert = 1'b1;
               state_in   = ST_OUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_CAN_SCAN: begin
            if (stat.scan_end) begin
               cmd.emit_plain = 1'b1;
               state_in       = ST_OUT;
            end else if (stat.id_hit) begin
               cmd.remove = 1'b1;
               state_in   = ST_OUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_taken) begin
               state_in = stat.out_last ? ST_IDLE : ST_TICK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/stq_dp.sv =====
module stq_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [stq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  stq_pkg::cmd_type                 cmd,
   output stq_pkg::stat_type                stat,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output stq_pkg::rsp_type                 rsp
);
   import stq_pkg::*;

   entry_type        store_ff [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      id_ff, id_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [31:0]      dl_ff, cid_ff, now_ff;
   logic [15:0]      th_ff, rp_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic [IDX_W-1:0] idx;
   entry_type        cur;
   logic             head_due, next_due, do_remove;
   logic [CNT_W-1:0] rm_pos;
   logic [31:0]      next_id;
   entry_type        new_entry;

   assign idx       = scan_ff[IDX_W-1:0];
   assign cur       = store_ff[idx];
   assign next_id   = id_ff + 32'd1;
   assign head_due  = (count_ff != '0) && (store_ff[0].deadline <= now_ff);
   assign next_due  = (count_ff > CNT_W'(1)) && (store_ff[1].deadline <= now_ff);
   assign do_remove = cmd.remove || (cmd.tick && head_due);
   assign rm_pos    = cmd.tick ? '0 : scan_ff;
   assign new_entry = '{deadline: dl_ff, id: next_id, thread: th_ff, rpc: rp_ff};

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.scan_end  = (scan_ff >= count_ff);
   assign stat.ins_stop  = (scan_ff >= count_ff) || (cur.deadline > dl_ff);
   assign stat.id_hit    = (cur.id == cid_ff);
   assign stat.out_taken = out_valid_ff && rsp_tready;
   assign stat.out_last  = out_ff.last;

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

   always_comb begin
      count_in = count_ff;
      id_in    = id_ff;
      scan_in  = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
      end else if (cmd.scan_next) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
         id_in    = next_id;
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      out_in       = '0;
      out_in.last  = 1'b1;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (cmd.emit_full) begin
         out_in.status = 1'b1;
         out_valid_in  = 1'b1;
      end else if (cmd.emit_plain || cmd.remove) begin
         out_valid_in = 1'b1;
      end else if (cmd.insert) begin
         out_in.new_id = next_id;
         out_valid_in  = 1'b1;
      end else if (cmd.tick) begin
         out_valid_in = 1'b1;
         if (head_due) begin
            out_in.expired        = 1'b1;
            out_in.expired_id     = store_ff[0].id;
            out_in.expired_thread = store_ff[0].thread;
            out_in.expired_rpc    = store_ff[0].rpc;
            out_in.last           = !next_due;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         id_ff        <= '0;
         scan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         id_ff        <= id_in;
         scan_ff      <= scan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_in && !out_valid_ff || cmd.tick) begin
         out_ff <= out_in;
      end
      if (cmd.load) begin
         dl_ff  <= req_tdata[31:0];
         th_ff  <= req_tdata[47:32];
         rp_ff  <= req_tdata[63:48];
         cid_ff <= req_tdata[95:64];
         now_ff <= req_tdata[127:96];
      end
   end

   // Shift the sorted store up on insert, down on remove.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 1; i < DEPTH; i++) begin
            if (CNT_W'(i) > scan_ff) begin
               store_ff[i] <= store_ff[i-1];
            end
         end
         store_ff[idx] <= new_entry;
      end else if (do_remove) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (CNT_W'(i) >= rm_pos) begin
               store_ff[i] <= store_ff[i+1];
            end
         end
      end
   end

endmodule

// ===== hw/rtl/sorted_timer_queue_unit.sv =====
// Sorted timer queue: up to DEPTH timers kept in ascending deadline order.
// Request channel (req_*): tuser carries the request kind (register, cancel,
// tick); tdata carries deadline, thread handle, callback number, cancel id
// and current tick. Response channel (rsp_*): one response per register,
// cancel or unused-code request; a tick request yields one response per
// expired timer in deadline order (or a single empty response), with
// tlast on the final one. Equal deadlines leave first in, first out. Ids
// count up from 1 and wrap. A request is taken only while the unit is idle.
// Register scans the store one entry a cycle for its slot and then
// responds. Cancel scans the same way for the id and checks every stored
// entry on a miss. A tick emits its expired timers one at a time through
// the output register and looks at the next only once the last is taken.
// The unit has a single scan pointer and one output register.
// Reset empties the queue and clears the id counter; store contents are left
// as they are and never read before written.
// A stalled receiver holds the response in the output register; the unit
// takes no further work until every response of the request is taken.
module sorted_timer_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] deadline, [47:32] thread_handle, [63:48] rpc_number,
   // [95:64] cancel_id, [127:96] now_tick
   input  logic [stq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] req_type
   input  logic [stq_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] new_id, [63:32] expired_id, [79:64] expired_thread,
   // [95:80] expired_rpc
   output logic [stq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] status, [1] expired
   output logic [stq_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast
);
   import stq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp;

   stq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   stq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp        (rsp)
   );

   // Pack the response fields onto the stream ports.
   assign rsp_tdata = {rsp.expired_rpc, rsp.expired_thread, rsp.expired_id, rsp.new_id};
   assign rsp_tuser = {rsp.expired, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

// ===== tb/tb_sorted_timer_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_timer_queue_unit;

   // Request code that the unit must answer with a plain response and ignore.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off to fill the unit
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
   localparam int DRAIN_CYCLES   = 40;    // room for a tick that expires every timer
   localparam int MAX_GAP        = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [1:0]       kind;
      logic [31:0]      deadline;
      logic [15:0]      thread;
      logic [15:0]      rpc;
      logic [31:0]      cancel_id;
      logic [31:0]      now_tick;
      bit               fixed;      // response typed into the row
      stq_pkg::rsp_type rsp;
   } stim_row_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [stq_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [stq_pkg::REQ_USER_W-1:0]  req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [stq_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [stq_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                            rsp_tlast;

   // Typed response that travels beside the request it belongs to.
   bit                              row_fixed = 1'b0;
   stq_pkg::rsp_type                row_rsp   = '0;

   // Shadow of the timer queue: entries in deadline order and the id counter.
   stq_pkg::entry_type              shadow_timers[$];
   logic [31:0]                     shadow_id = '0;
   // Responses still owed by the unit, oldest first.
   stq_pkg::rsp_type                timer_rsp_q[$];

   stim_row_type                    directed_rows[$];
   int                              send_idle_pct = 0;
   int                              rsp_idle_pct  = 0;
   bit                              rsp_hold_request = 1'b0;
   int                              fill_left = 0;
   logic [31:0]                     sim_now;
   int                              fault_count = 0;
   int                              stall_cycles = 0;
   stq_pkg::rsp_type                seen_rsp;
   stq_pkg::rsp_type                want_rsp;

   sorted_timer_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic stq_pkg::rsp_type plain_rsp(input logic status, input logic [31:0] id);
      stq_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      r.new_id = id;
      r.last   = 1'b1;
      return r;
   endfunction

   // Advance the shadow queue by one request and queue the responses it owes.
   function automatic void step_timer_queue(input logic [1:0] kind, input logic [127:0] data);
      stq_pkg::entry_type ent;
      stq_pkg::rsp_type   r;
      logic [31:0]        now;
      int                 pos;
      bit                 swept;
      now   = data[127:96];
      swept = 1'b0;
      r     = plain_rsp(1'b0, '0);
      case (kind)
         stq_pkg::REQ_REGISTER: begin
            if (shadow_timers.size() >= stq_pkg::DEPTH) begin
               r.status = 1'b1;
            end else begin
               shadow_id      = shadow_id + 32'd1;
               ent.deadline   = data[31:0];
               ent.id         = shadow_id;
               ent.thread     = data[47:32];
               ent.rpc        = data[63:48];
               // Insert behind equal deadlines so they leave first in, first out.
               pos = 0;
               while (pos < shadow_timers.size() && shadow_timers[pos].deadline <= ent.deadline)
                  pos++;
               shadow_timers.insert(pos, ent);
               r.new_id = shadow_id;
            end
         end
         stq_pkg::REQ_CANCEL: begin
            // Drop only the first match; a missing id still answers ok.
            for (pos = 0; pos < shadow_timers.size(); pos++) begin
               if (shadow_timers[pos].id == data[95:64]) begin
                  shadow_timers.delete(pos);
                  break;
               end
            end
         end
         stq_pkg::REQ_TICK: begin
            while (shadow_timers.size() != 0 && shadow_timers[0].deadline <= now) begin
               ent              = shadow_timers.pop_front();
               r                = '0;
               r.expired        = 1'b1;
               r.expired_id     = ent.id;
               r.expired_thread = ent.thread;
               r.expired_rpc    = ent.rpc;
               r.last           = (shadow_timers.size() == 0) ||
                                  (shadow_timers[0].deadline > now);
               timer_rsp_q.push_back(r);
               swept = 1'b1;
            end
            r = plain_rsp(1'b0, '0);
         end
         default: ;
      endcase
      if (!swept)
         timer_rsp_q.push_back(r);
   endfunction

   task automatic add_row(input logic [1:0] kind, input logic [31:0] deadline,
                          input logic [15:0] thread, input logic [15:0] rpc,
                          input logic [31:0] cancel_id, input logic [31:0] now_tick,
                          input bit fixed, input stq_pkg::rsp_type rsp);
      stim_row_type row;
      row.kind      = kind;
      row.deadline  = deadline;
      row.thread    = thread;
      row.rpc       = rpc;
      row.cancel_id = cancel_id;
      row.now_tick  = now_tick;
      row.fixed     = fixed;
      row.rsp       = rsp;
      directed_rows.push_back(row);
   endtask

   // Offer one request after a random idle gap and hold it until it is taken.
   task automatic offer_request(input logic [1:0] kind, input logic [127:0] data,
                                input bit fixed, input stq_pkg::rsp_type rsp);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      row_fixed  <= fixed;
      row_rsp    <= rsp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Build a random request. Most deadlines sit just ahead of a running tick
   // so that sweeps expire a few timers at a time; bursts of registers fill
   // the queue, and cancels mostly hit a live id.
   task automatic make_random_request(output logic [1:0] kind, output logic [127:0] data);
      logic [31:0] dl;
      logic [31:0] cid;
      logic [31:0] now;
      logic [15:0] th;
      logic [15:0] rp;
      int          pick;
      dl   = $urandom;
      cid  = $urandom;
      now  = $urandom;
      th   = 16'($urandom_range(0, 65535));
      rp   = 16'($urandom_range(0, 65535));
      pick = $urandom_range(99);
      if (fill_left != 0) begin
         kind = stq_pkg::REQ_REGISTER;
         fill_left--;
      end else if (pick < 3) begin
         kind      = stq_pkg::REQ_REGISTER;
         fill_left = stq_pkg::DEPTH + 1;
      end else if (pick < 45) begin
         kind = stq_pkg::REQ_REGISTER;
      end else if (pick < 65) begin
         kind = stq_pkg::REQ_CANCEL;
      end else if (pick < 95) begin
         kind = stq_pkg::REQ_TICK;
      end else begin
         kind = REQ_UNUSED;
      end
      if (kind == stq_pkg::REQ_REGISTER && $urandom_range(99) >= 12)
         dl = sim_now + 32'($urandom_range(0, 300));
      if (kind == stq_pkg::REQ_CANCEL && shadow_timers.size() != 0 && $urandom_range(99) < 70)
         cid = shadow_timers[$urandom_range(0, shadow_timers.size() - 1)].id;
      if (kind == stq_pkg::REQ_TICK) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            now = '1;
         end else if (pick >= 12) begin
            sim_now = sim_now + 32'($urandom_range(0, 60));
            now     = sim_now;
         end
      end
      data = {now, cid, rp, th, dl};
   endtask

   // Receiver: random stalls per cycle, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Check responses against the oldest owed one, then predict any request
   // taken at this edge. Count cycles without a handshake for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.status         = rsp_tuser[0];
            seen_rsp.expired        = rsp_tuser[1];
            seen_rsp.new_id         = rsp_tdata[31:0];
            seen_rsp.expired_id     = rsp_tdata[63:32];
            seen_rsp.expired_thread = rsp_tdata[79:64];
            seen_rsp.expired_rpc    = rsp_tdata[95:80];
            seen_rsp.last           = rsp_tlast;
            if (timer_rsp_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected response: st=%0b id=%0h exp=%0b eid=%0h th=%0h rpc=%0h last=%0b",
                           seen_rsp.status, seen_rsp.new_id, seen_rsp.expired,
                           seen_rsp.expired_id, seen_rsp.expired_thread,
                           seen_rsp.expired_rpc, seen_rsp.last);
            end else begin
               want_rsp = timer_rsp_q.pop_front();
               if (seen_rsp.status !== want_rsp.status ||
                   seen_rsp.new_id !== want_rsp.new_id ||
                   seen_rsp.expired !== want_rsp.expired ||
                   seen_rsp.expired_id !== want_rsp.expired_id ||
                   seen_rsp.expired_thread !== want_rsp.expired_thread ||
                   seen_rsp.expired_rpc !== want_rsp.expired_rpc ||
                   seen_rsp.last !== want_rsp.last) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("response mismatch at %0t", $realtime);
                     $display("  want st=%0b id=%0h exp=%0b eid=%0h th=%0h rpc=%0h last=%0b",
                              want_rsp.status, want_rsp.new_id, want_rsp.expired,
                              want_rsp.expired_id, want_rsp.expired_thread,
                              want_rsp.expired_rpc, want_rsp.last);
                     $display("  got  st=%0b id=%0h exp=%0b eid=%0h th=%0h rpc=%0h last=%0b",
                              seen_rsp.status, seen_rsp.new_id, seen_rsp.expired,
                              seen_rsp.expired_id, seen_rsp.expired_thread,
                              seen_rsp.expired_rpc, seen_rsp.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_timer_queue(req_tuser, req_tdata);
            // A typed row owes exactly one response; it replaces the prediction.
            if (row_fixed) begin
               void'(timer_rsp_q.pop_back());
               timer_rsp_q.push_back(row_rsp);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [1:0]   kind;
      logic [127:0] data;
      int           i;

      sim_now = 32'($urandom_range(0, 1000));

      // Directed requests: empty queue, absent id, unused code, field extremes,
      // equal deadlines leaving in order, cancel of a live timer, queue full.
      add_row(stq_pkg::REQ_TICK, '0, '0, '0, '0, '0, 1'b1, plain_rsp(1'b0, '0));
      add_row(stq_pkg::REQ_CANCEL, '0, '0, '0, '1, '0, 1'b1, plain_rsp(1'b0, '0));
      add_row(REQ_UNUSED, '1, '1, '1, '1, '1, 1'b1, plain_rsp(1'b0, '0));
      add_row(stq_pkg::REQ_REGISTER, '1, '1, '1, '0, '0, 1'b1, plain_rsp(1'b0, 32'd1));
      add_row(stq_pkg::REQ_REGISTER, '0, '0, '0, '0, '0, 1'b1, plain_rsp(1'b0, 32'd2));
      add_row(stq_pkg::REQ_REGISTER, 32'd100, 16'hA5A5, 16'h5A5A, '0, '0,
              1'b1, plain_rsp(1'b0, 32'd3));
      add_row(stq_pkg::REQ_REGISTER, 32'd100, 16'h5A5A, 16'hA5A5, '0, '0,
              1'b1, plain_rsp(1'b0, 32'd4));
      add_row(stq_pkg::REQ_TICK, '0, '0, '0, '0, 32'd100, 1'b0, '0);
      add_row(stq_pkg::REQ_CANCEL, '0, '0, '0, 32'd1, '0, 1'b1, plain_rsp(1'b0, '0));
      // Fill the now empty queue with mixed and repeated deadlines.
      for (i = 0; i < stq_pkg::DEPTH; i++)
         add_row(stq_pkg::REQ_REGISTER, 32'((i * 7) % 5 * 100 + i % 3), 16'(i), 16'(~i),
                 '0, '0, 1'b0, '0);
      add_row(stq_pkg::REQ_REGISTER, 32'h8000_0000, '1, '1, '0, '0,
              1'b1, plain_rsp(1'b1, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // First sender idles 34 %, receiver 48 %.
      send_idle_pct = 34;
      rsp_idle_pct  = 48;
      foreach (directed_rows[r])
         offer_request(directed_rows[r].kind,
                       {directed_rows[r].now_tick, directed_rows[r].cancel_id,
                        directed_rows[r].rpc, directed_rows[r].thread,
                        directed_rows[r].deadline},
                       directed_rows[r].fixed, directed_rows[r].rsp);
      for (i = 0; i < 70; i++) begin
         make_random_request(kind, data);
         offer_request(kind, data, 1'b0, '0);
      end

      // Swap the idle rates.
      send_idle_pct = 48;
      rsp_idle_pct  = 34;
      for (i = 0; i < 70; i++) begin
         make_random_request(kind, data);
         offer_request(kind, data, 1'b0, '0);
      end

      // No idling; hold the receiver off while requests keep coming.
      send_idle_pct    = 0;
      rsp_idle_pct     = 0;
      rsp_hold_request = 1'b1;
      for (i = 0; i < 60; i++) begin
         make_random_request(kind, data);
         offer_request(kind, data, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (timer_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && timer_rsp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/stq_pkg.sv
hw/rtl/stq_ctrl.sv
hw/rtl/stq_dp.sv
hw/rtl/sorted_timer_queue_unit.sv
tb/tb_sorted_timer_queue_unit.sv
